[rtl/tcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcr_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int LANES       = 6;   // start x, y, z then end x, y, z
  localparam int NTAPS       = 4;
  localparam int HIST_DEPTH  = 5;
  localparam int FEED_DEPTH  = HIST_DEPTH - 3;
  localparam int VERTS       = 40;
  localparam int SEG_LEN     = 10;
  localparam int FRAC        = 10;  // weights are in units of 1/1024
  localparam int WEIGHT_W    = 12;
  localparam int PROD_W      = COORD_WIDTH + WEIGHT_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int IDX_W       = $clog2(VERTS);
  localparam int J_W         = $clog2(SEG_LEN);
  localparam int PAIR_W      = LANES * COORD_WIDTH;
  localparam int IN_W        = ((PAIR_W + 7) / 8) * 8;
  localparam int OUT_W       = ((IDX_W + PAIR_W + 7) / 8) * 8;
  localparam int QDEPTH      = 2;
  localparam int Q_AW        = $clog2(QDEPTH);
  localparam int Q_CW        = $clog2(QDEPTH + 1);

  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(VERTS - 1);
  localparam logic [J_W-1:0]   J_LAST = J_W'(SEG_LEN - 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [WEIGHT_W-1:0]    wt_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam acc_t   RND_POS = acc_t'(1 << (FRAC - 1));
  localparam acc_t   RND_NEG = acc_t'((1 << (FRAC - 1)) - 1);

  // catmull-rom weights at t = j/8; the control point row (j = 9) reuses t = 1
  localparam wt_t WEIGHTS [SEG_LEN][NTAPS] = '{
    '{  0, 1024,    0,   0},
    '{-49,  987,   93,  -7},
    '{-72,  888,  232, -24},
    '{-75,  745,  399, -45},
    '{-64,  576,  576, -64},
    '{-45,  399,  745, -75},
    '{-24,  232,  888, -72},
    '{ -7,   93,  987, -49},
    '{  0,    0, 1024,   0},
    '{  0,    0, 1024,   0}
  };

  typedef struct packed {
    coord_t end_z;
    coord_t end_y;
    coord_t end_x;
    coord_t start_z;
    coord_t start_y;
    coord_t start_x;
  } pair_t;

  typedef struct packed {
    logic  valid;
    pair_t data;
  } qout_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

`default_nettype wire

[rtl/tcr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcr_front import tcr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,
  output qout_t           q,
  input  logic            q_pop
);

  pair_t            mem [QDEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_CW-1:0]  count;
  logic             push;

  assign s_tready = (count != Q_CW'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q.valid  = (count != '0);
  assign q.data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= pair_t'(s_tdata[PAIR_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      count <= count + Q_CW'(push) - Q_CW'(q_pop);
    end
  end

endmodule

`default_nettype wire

[rtl/tcr_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcr_lane import tcr_pkg::*; (
  input  logic   clk,
  input  logic   adv,
  input  coord_t pt [NTAPS],
  input  wt_t    wt [NTAPS],
  output coord_t res
);

  prod_t                       prod [NTAPS];
  acc_t                        s01;
  acc_t                        s23;
  acc_t                        tot;
  acc_t                        rnd;
  logic [ACC_W-FRAC-1:0]       q;
  logic [ACC_W-FRAC-COORD_WIDTH:0] top;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NTAPS; i++) begin
        prod[i] <= pt[i] * wt[i];
      end
      s01 <= acc_t'(prod[0]) + acc_t'(prod[1]);
      s23 <= acc_t'(prod[2]) + acc_t'(prod[3]);
      tot <= s01 + s23;
    end
  end

  // round half away from zero, then clamp to the coordinate range
  always_comb begin
    rnd = tot + (tot[ACC_W-1] ? RND_NEG : RND_POS);
    q   = rnd[ACC_W-1:FRAC];
    top = q[ACC_W-FRAC-1:COORD_WIDTH-1];
    if ((&top) || (~|top)) begin
      res = q[COORD_WIDTH-1:0];
    end else if (q[ACC_W-FRAC-1]) begin
      res = C_MIN;
    end else begin
      res = C_MAX;
    end
  end

endmodule

`default_nettype wire

[rtl/tcr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcr_back import tcr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  qout_t            q,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  state_t           state;
  state_t           state_next;
  logic             adv;
  logic             issue;
  logic [IDX_W-1:0] k;
  logic [J_W-1:0]   j;

  coord_t           nw   [LANES];
  coord_t           hist [HIST_DEPTH][LANES];
  coord_t           win  [NTAPS][LANES];
  coord_t           feed [FEED_DEPTH][LANES];
  coord_t           lane_pt  [LANES][NTAPS];
  wt_t              lane_wt  [NTAPS];
  coord_t           lane_res [LANES];

  logic [2:0]       v;
  logic [IDX_W-1:0] idx [3];
  coord_t           out_c [LANES];
  logic [IDX_W-1:0] out_idx;

  assign adv = !m_tvalid || m_tready;

  assign nw[0] = q.data.start_x;
  assign nw[1] = q.data.start_y;
  assign nw[2] = q.data.start_z;
  assign nw[3] = q.data.end_x;
  assign nw[4] = q.data.end_y;
  assign nw[5] = q.data.end_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    q_pop      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q.valid) begin
          q_pop      = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv) begin
          issue = 1'b1;
          if (k == K_LAST) begin
            // chain straight into the next pair when one is queued
            if (q.valid) begin
              q_pop = 1'b1;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      j <= '0;
    end else if (q_pop) begin
      k <= '0;
      j <= '0;
    end else if (issue) begin
      k <= k + IDX_W'(1);
      j <= (j == J_LAST) ? '0 : j + J_W'(1);
    end
  end

  // control point history, entry 0 newest
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < HIST_DEPTH; e++) begin
        for (int l = 0; l < LANES; l++) begin
          hist[e][l] <= '0;
        end
      end
    end else if (q_pop) begin
      for (int l = 0; l < LANES; l++) begin
        hist[0][l] <= nw[l];
      end
      for (int e = 1; e < HIST_DEPTH; e++) begin
        for (int l = 0; l < LANES; l++) begin
          hist[e][l] <= hist[e-1][l];
        end
      end
    end
  end

  // four-point window slides one point per segment, end points duplicated
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int l = 0; l < LANES; l++) begin
        win[0][l]  <= nw[l];
        win[1][l]  <= nw[l];
        win[2][l]  <= hist[0][l];
        win[3][l]  <= hist[1][l];
        feed[0][l] <= hist[2][l];
        feed[1][l] <= hist[3][l];
      end
    end else if (issue && (j == J_LAST)) begin
      for (int l = 0; l < LANES; l++) begin
        win[0][l]  <= win[1][l];
        win[1][l]  <= win[2][l];
        win[2][l]  <= win[3][l];
        win[3][l]  <= feed[0][l];
        feed[0][l] <= feed[1][l];
      end
    end
  end

  always_comb begin
    for (int t = 0; t < NTAPS; t++) begin
      lane_wt[t] = WEIGHTS[j][t];
      for (int l = 0; l < LANES; l++) begin
        lane_pt[l][t] = win[t][l];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tcr_lane u_lane (
      .clk (clk),
      .adv (adv),
      .pt  (lane_pt[l]),
      .wt  (lane_wt),
      .res (lane_res[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v        <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v        <= {v[1:0], issue};
      m_tvalid <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx[0]  <= k;
      idx[1]  <= idx[0];
      idx[2]  <= idx[1];
      out_idx <= idx[2];
      m_tlast <= (idx[2] == K_LAST);
      for (int l = 0; l < LANES; l++) begin
        out_c[l] <= lane_res[l];
      end
    end
  end

  assign m_tdata = OUT_W'({out_c[5], out_c[4], out_c[3], out_c[2], out_c[1], out_c[0],
                           out_idx});

endmodule

`default_nettype wire

[rtl/trail_catmull_rom_tessellator_top.sv]
// channel   dir  signals                       beat contents (lowest bits first)
// s_*       in   s_tvalid s_tready s_tdata     start_x start_y start_z end_x end_y end_z
// m_*       out  m_tvalid m_tready m_tdata     vertex_index out_start_x..z out_end_x..z, pad
//                m_tlast                       high on vertex 39
//
// each input beat yields 40 output beats, one per cycle while m_tready is high;
// the first vertex passes the product, pair-sum, total and output registers after
// the pair leaves the two-entry queue
// rst clears the point history to the origin, the queue and the sequencer
// a stall on m_tready freezes the lanes; s_tready drops only when the queue is full
`timescale 1ns / 1ps
`default_nettype none

module trail_catmull_rom_tessellator_top import tcr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // vertex_index, out_start_x/y/z, out_end_x/y/z, zeros
  output logic             m_tlast
);

  qout_t q;
  logic  q_pop;

  tcr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q        (q),
    .q_pop    (q_pop)
  );

  tcr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q        (q),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

[rtl/tcr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcr_checker import tcr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  localparam int CO_LO = IDX_W;
  localparam int CO_HI = IDX_W + PAIR_W - 1;

  // tlast marks exactly the final vertex
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[IDX_W-1:0] == K_LAST)))
    else $error("tlast does not match the final vertex");

  // inside a run the vertices follow without gaps
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && (m_tdata[IDX_W-1:0] == $past(m_tdata[IDX_W-1:0]) + IDX_W'(1))))
    else $error("vertex index skipped or run broken");

  // t = 1 of a segment and the control point after it coincide
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && ((m_tdata[IDX_W-1:0] == IDX_W'(8)) ||
      (m_tdata[IDX_W-1:0] == IDX_W'(18)) || (m_tdata[IDX_W-1:0] == IDX_W'(28)) ||
      (m_tdata[IDX_W-1:0] == IDX_W'(38)))) |=>
      (m_tdata[CO_HI:CO_LO] == $past(m_tdata[CO_HI:CO_LO])))
    else $error("segment end differs from its control point");

  // a stalled beat holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output beat changed while stalled");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind trail_catmull_rom_tessellator_top tcr_checker u_checker (.*);

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tcr_pkg::*;

  localparam int N_RANDOM   = 330;
  localparam int IDLE_PCT   = 37;
  localparam int DRAIN_WAIT = 20;
  localparam int STALL_MAX  = 1000;

  typedef struct packed {
    logic                    last;
    logic [IDX_W-1:0]        idx;
    coord_t [LANES-1:0]      lane;
  } vertex_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  logic [IN_W-1:0]  pair_q [$];
  vertex_t          strip_q [$];
  longint           trail_hist [HIST_DEPTH][LANES];
  string            lane_name [LANES] = '{"out_start_x", "out_start_y", "out_start_z",
                                          "out_end_x", "out_end_y", "out_end_z"};

  int   pairs_in = 0;
  int   vertices_checked = 0;
  int   sat_hits = 0;
  int   errors = 0;
  int   stall_cycles = 0;
  bit   in_taken = 1'b0;
  logic calm;

  // no idling on either side for a stretch in the middle of the run
  assign calm = (pairs_in >= 120) && (pairs_in < 180);

  trail_catmull_rom_tessellator_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  function automatic pair_t point_pair(coord_t sx, coord_t sy, coord_t sz,
                                       coord_t ex, coord_t ey, coord_t ez);
    pair_t p;
    p.start_x = sx;
    p.start_y = sy;
    p.start_z = sz;
    p.end_x   = ex;
    p.end_y   = ey;
    p.end_z   = ez;
    return p;
  endfunction

  // one coordinate of the strip vertex at index k, from the current history
  function automatic coord_t spline_coord(int k, int lane);
    int     s, j, a, d;
    longint w0, w1, w2, w3, acc, q, hi, lo;
    s = k / SEG_LEN;
    j = k % SEG_LEN;
    if (j == SEG_LEN - 1) return coord_t'(trail_hist[s + 1][lane]);
    a = (s > 0) ? s - 1 : 0;
    d = (s + 2 < HIST_DEPTH) ? s + 2 : HIST_DEPTH - 1;
    w0 = -64 * j + 16 * j * j - j * j * j;
    w1 = 1024 - 40 * j * j + 3 * j * j * j;
    w2 = 64 * j + 32 * j * j - 3 * j * j * j;
    w3 = -8 * j * j + j * j * j;
    acc = w0 * trail_hist[a][lane] + w1 * trail_hist[s][lane]
        + w2 * trail_hist[s + 1][lane] + w3 * trail_hist[d][lane];
    // round to nearest, ties away from zero
    if (acc >= 0) q = (acc + 512) / 1024;
    else          q = -((-acc + 512) / 1024);
    hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (q > hi) begin
      q = hi;
      sat_hits++;
    end else if (q < lo) begin
      q = lo;
      sat_hits++;
    end
    return coord_t'(q);
  endfunction

  initial begin
    int              n, i, style;
    coord_t          walk [LANES];
    coord_t          v;
    logic [IN_W-1:0] beat;

    foreach (trail_hist[a, b]) trail_hist[a][b] = 0;

    // directed: origin, simple values, extremes, overshoot patterns
    pair_q.push_back(point_pair(0, 0, 0, 0, 0, 0));
    pair_q.push_back(point_pair(256, -256, 512, -512, 1, -1));
    pair_q.push_back(point_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    pair_q.push_back(point_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    pair_q.push_back(point_pair(-1, -1, -1, -1, -1, -1));
    // min, max, max, min overshoots past the top; mirrored on the end strip
    pair_q.push_back(point_pair(C_MIN, C_MAX, 0, C_MAX, C_MIN, 0));
    pair_q.push_back(point_pair(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
    pair_q.push_back(point_pair(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
    pair_q.push_back(point_pair(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX));
    pair_q.push_back(point_pair(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX));
    pair_q.push_back(point_pair(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
    pair_q.push_back(point_pair(24'sh123456, -24'sh234567, 24'sh555555,
                                -24'sh2aaaaa, 24'sh7f0001, -24'sh000100));
    pair_q.push_back(point_pair(1, -1, 0, C_MAX, C_MIN, 1));
    pair_q.push_back(point_pair(0, 0, 0, 0, 0, 0));

    foreach (walk[i]) walk[i] = coord_t'($urandom);
    for (n = 0; n < N_RANDOM; n++) begin
      style = $urandom_range(99);
      for (i = 0; i < LANES; i++) begin
        if (style < 55) begin
          // smooth trail: small steps from the last point
          walk[i] = walk[i] + coord_t'(int'($urandom_range(4095)) - 2048);
          v = walk[i];
        end else if (style < 75) begin
          v = coord_t'($urandom);
        end else if (style < 88) begin
          case ($urandom_range(4))
            0:       v = C_MAX;
            1:       v = C_MIN;
            2:       v = 0;
            3:       v = -1;
            default: v = 1;
          endcase
        end else begin
          v = coord_t'(int'($urandom_range(1023)) - 512);
        end
        beat[i * COORD_WIDTH +: COORD_WIDTH] = v;
      end
      pair_q.push_back(beat);
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pair_q.size() != 0 || s_tvalid) @(posedge clk);
    while (strip_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("tessellated %0d point pairs into %0d checked vertex beats",
             pairs_in, vertices_checked);
    $display("%0d coordinates saturated, %0d mismatches", sat_hits, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // driver: new beat at the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (pair_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          s_tdata  <= pair_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin : monitor
    vertex_t want;
    coord_t  got;
    int      k, i;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (strip_q.size() == 0) begin
          $display("%0t: unexpected vertex beat, expected none, got index %0d",
                   $time, m_tdata[IDX_W-1:0]);
          errors++;
        end else begin
          want = strip_q.pop_front();
          vertices_checked++;
          if (m_tdata[IDX_W-1:0] !== want.idx) begin
            $display("%0t: vertex_index expected %0d got %0d",
                     $time, want.idx, m_tdata[IDX_W-1:0]);
            errors++;
          end
          for (i = 0; i < LANES; i++) begin
            got = m_tdata[IDX_W + i * COORD_WIDTH +: COORD_WIDTH];
            if (got !== want.lane[i]) begin
              $display("%0t: vertex %0d %s expected %0d got %0d",
                       $time, want.idx, lane_name[i], want.lane[i], got);
              errors++;
            end
          end
          if (m_tlast !== want.last) begin
            $display("%0t: vertex %0d last expected %0b got %0b",
                     $time, want.idx, want.last, m_tlast);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        for (k = HIST_DEPTH - 1; k > 0; k--)
          for (i = 0; i < LANES; i++) trail_hist[k][i] = trail_hist[k - 1][i];
        for (i = 0; i < LANES; i++)
          trail_hist[0][i] = coord_t'(s_tdata[i * COORD_WIDTH +: COORD_WIDTH]);
        for (k = 0; k < VERTS; k++) begin
          want.idx  = IDX_W'(k);
          want.last = (k == VERTS - 1);
          for (i = 0; i < LANES; i++) want.lane[i] = spline_coord(k, i);
          strip_q.push_back(want);
        end
        pairs_in++;
        in_taken = 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("%0t: no beat for %0d cycles", $time, stall_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
rtl/tcr_pkg.sv
rtl/tcr_front.sv
rtl/tcr_lane.sv
rtl/tcr_back.sv
rtl/trail_catmull_rom_tessellator_top.sv
rtl/tcr_checker.sv
test/tb_top.sv
